>>> src/odometer_frame_decoder_unit_defines.svh
// assertion macros of the odometer frame decoder rtl
`ifndef ODOMETER_FRAME_DECODER_UNIT_DEFINES_SVH
`define ODOMETER_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ofd assertion failed");

// next-cycle implication, disabled in reset
`define OFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ofd assertion failed");

`endif

>>> src/ofd_pkg.sv
// types and constants of the odometer frame decoder
package ofd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 7;
  localparam int MIN_FRAME_BYTES     = 6;
  localparam int WINDOW_CELLS        = 5;
  localparam int BYTE_W              = 6;
  localparam int IDX_W               = 3;
  localparam int COUNT_W             = 12;
  localparam int TIME_W              = 18;
  localparam logic [TIME_W-1:0] TIME_WRAP = 18'h10000;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               checksum_bad;
    logic [COUNT_W-1:0] raw_count;
    logic [TIME_W-1:0]  raw_time;
    logic [COUNT_W-1:0] count_delta;
    logic [TIME_W-1:0]  time_delta;
  } ofd_result_t;

endpackage

>>> src/ofd_cell.sv
// one cell of the frame byte shift line
module ofd_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [ofd_pkg::BYTE_W-1:0] din,
  output logic [ofd_pkg::BYTE_W-1:0] q
);
  import ofd_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

>>> src/ofd_delta.sv
// previous frame time and count, and the deltas against them
module ofd_delta (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [ofd_pkg::COUNT_W-1:0] raw_count,
  input  logic [ofd_pkg::TIME_W-1:0]  raw_time,
  output logic [ofd_pkg::COUNT_W-1:0] count_delta,
  output logic [ofd_pkg::TIME_W-1:0]  time_delta
);
  import ofd_pkg::*;

  logic [COUNT_W-1:0] last_count;
  logic [TIME_W-1:0]  last_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      last_time  <= '0;
    end else if (load) begin
      last_count <= raw_count;
      last_time  <= raw_time;
    end
  end

  always_comb begin
    // wrap rule adds 2^16 when time did not advance
    if (raw_time > last_time) begin
      time_delta = raw_time - last_time;
    end else begin
      time_delta = raw_time + TIME_WRAP - last_time;
    end
    // count going back re-bases, delta zero
    if (raw_count < last_count) begin
      count_delta = '0;
    end else begin
      count_delta = raw_count - last_count;
    end
  end

endmodule

>>> src/odometer_frame_decoder_unit.sv
// odometer frame decoder top level: byte shift line, decode and output buffer
//
//  channel | signals                        | carries
//  --------+--------------------------------+-----------------------------------
//  in      | in_valid, in_ready, rx_byte    | one received serial byte
//  out     | out_valid, out_ready, kind ... | decoded frame or error report
//
// one byte is taken per cycle while in_ready is high; each result is registered
// the rate is set by the output register and its one-entry skid stage
// in_ready drops only while the skid stage holds a result
// rst (synchronous) clears the byte count, last time, last count and valids
module odometer_frame_decoder_unit #(
  parameter int MAX_FRAME_BYTES = ofd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic                        checksum_bad,
  output logic [ofd_pkg::COUNT_W-1:0] raw_count,
  output logic [ofd_pkg::TIME_W-1:0]  raw_time,
  output logic [ofd_pkg::COUNT_W-1:0] count_delta,
  output logic [ofd_pkg::TIME_W-1:0]  time_delta
);
  import ofd_pkg::*;
  `include "odometer_frame_decoder_unit_defines.svh"

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAME_BYTES);
  localparam logic [IDX_W-1:0] MIN_IDX = IDX_W'(MIN_FRAME_BYTES);

  logic [IDX_W-1:0]  byte_index;
  logic [IDX_W-1:0]  byte_index_next;
  logic [IDX_W-1:0]  idx_inc;
  logic [BYTE_W-1:0] cell_q [WINDOW_CELLS];
  logic [BYTE_W-1:0] rx_low;
  logic              in_fire;
  logic              out_fire;
  logic              frame_byte;
  logic              too_long;
  logic              has_res;
  logic              decode_ok;
  logic              store;
  logic [COUNT_W-1:0] dec_count;
  logic [TIME_W-1:0]  dec_time;
  logic [COUNT_W-1:0] dec_count_delta;
  logic [TIME_W-1:0]  dec_time_delta;
  ofd_result_t       res;
  ofd_result_t       out_res;
  ofd_result_t       skid_res;
  logic              skid_valid;
  logic              out_err;
  logic              err_fields_clear;

  assign in_ready = ~skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  assign rx_low     = rx_byte[BYTE_W-1:0];
  assign frame_byte = rx_byte[7];
  assign too_long   = frame_byte & (byte_index >= MAX_IDX);
  assign idx_inc    = byte_index + IDX_W'(1);
  assign has_res    = frame_byte & (too_long | ~rx_byte[6]);
  assign decode_ok  = frame_byte & ~too_long & ~rx_byte[6] & (idx_inc >= MIN_IDX);
  assign store      = in_fire & frame_byte & ~too_long;

  // shift line: cell 0 holds the newest stored byte
  for (genvar i = 0; i < WINDOW_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      ofd_cell u_cell (.clk(clk), .shift(store), .din(rx_low), .q(cell_q[i]));
    end else begin : g_tail
      ofd_cell u_cell (.clk(clk), .shift(store), .din(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  // closing byte is the live input byte; the five window cells hold the bytes before it
  assign dec_count = {cell_q[4], cell_q[3]};
  assign dec_time  = {cell_q[2], cell_q[1], cell_q[0]};

  ofd_delta u_delta (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire & decode_ok),
    .raw_count  (dec_count),
    .raw_time   (dec_time),
    .count_delta(dec_count_delta),
    .time_delta (dec_time_delta)
  );

  always_comb begin
    res = '0;
    if (too_long) begin
      res.kind = KIND_LONG;
    end else if (decode_ok) begin
      res.kind         = KIND_FRAME;
      res.checksum_bad = |(cell_q[4] ^ cell_q[3] ^ cell_q[2] ^ cell_q[1]
                           ^ cell_q[0] ^ rx_low);
      res.raw_count    = dec_count;
      res.raw_time     = dec_time;
      res.count_delta  = dec_count_delta;
      res.time_delta   = dec_time_delta;
    end else begin
      res.kind = KIND_SHORT;
    end
  end

  always_comb begin
    byte_index_next = byte_index;
    if (in_fire && frame_byte) begin
      if (too_long || !rx_byte[6]) begin
        byte_index_next = '0;
      end else begin
        byte_index_next = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid <= in_fire & has_res;
    end else if (in_fire && has_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || out_fire) begin
      out_res <= res;
    end else if (in_fire && has_res) begin
      skid_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign checksum_bad = out_res.checksum_bad;
  assign raw_count    = out_res.raw_count;
  assign raw_time     = out_res.raw_time;
  assign count_delta  = out_res.count_delta;
  assign time_delta   = out_res.time_delta;

  // error reports carry only their kind
  assign out_err          = out_valid & (out_res.kind != KIND_FRAME);
  assign err_fields_clear = ~out_res.checksum_bad & (raw_count == '0) & (raw_time == '0)
                            & (count_delta == '0) & (time_delta == '0);

  `OFD_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `OFD_ASSERT_IMPL(a_index_in_range, clk, rst, 1'b1, byte_index <= MAX_IDX)
  `OFD_ASSERT_IMPL(a_error_fields_zero, clk, rst, out_err, err_fields_clear)
  `OFD_ASSERT_NEXT(a_close_clears_index, clk, rst, in_fire && has_res, byte_index == '0)

endmodule
